[sv/fbm_pkg.sv]
// Shared types and constants for the frequency band meter with converter statistics.
package fbm_pkg;

  // Fixed field widths
  localparam int unsigned PERIOD_W   = 16;
  localparam int unsigned FREQ_W     = 20;
  localparam int unsigned BAND_W     = 3;
  localparam int unsigned CFG_W      = 20;
  localparam int unsigned CFG_ADDR_W = 3;

  // Register indexes
  localparam logic [CFG_ADDR_W-1:0] REG_MEASURE_PERIOD = 3'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_DISPLAY_PERIOD = 3'd1;
  localparam logic [CFG_ADDR_W-1:0] REG_NEUTRAL_FREQ   = 3'd2;
  localparam logic [CFG_ADDR_W-1:0] REG_VALID_A_FREQ   = 3'd3;
  localparam logic [CFG_ADDR_W-1:0] REG_VALID_B_FREQ   = 3'd4;
  localparam logic [CFG_ADDR_W-1:0] REG_BAND_TOL       = 3'd5;
  localparam logic [CFG_ADDR_W-1:0] REG_SILENCE_THR    = 3'd6;

  // Register reset values
  localparam logic [PERIOD_W-1:0] RST_MEASURE_PERIOD = 16'd50;
  localparam logic [PERIOD_W-1:0] RST_DISPLAY_PERIOD = 16'd500;
  localparam logic [FREQ_W-1:0]   RST_NEUTRAL_FREQ   = 20'd20000;
  localparam logic [FREQ_W-1:0]   RST_VALID_A_FREQ   = 20'd25000;
  localparam logic [FREQ_W-1:0]   RST_VALID_B_FREQ   = 20'd40000;
  localparam logic [FREQ_W-1:0]   RST_BAND_TOL       = 20'd2000;
  localparam logic [FREQ_W-1:0]   RST_SILENCE_THR    = 20'd100;

  typedef enum logic [BAND_W-1:0] {
    BAND_NONE    = 3'd0,
    BAND_NEUTRAL = 3'd1,
    BAND_VALID_A = 3'd2,
    BAND_VALID_B = 3'd3,
    BAND_UNKNOWN = 3'd4
  } band_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MUL_A,
    ST_MUL_B,
    ST_FREQ_GO,
    ST_FREQ_WAIT,
    ST_MEAN_GO,
    ST_MEAN_WAIT,
    ST_CLASSIFY,
    ST_EMIT
  } state_e;

endpackage

[sv/fbm_div.sv]
// Bit-serial restoring divider, one quotient bit per cycle.
module fbm_div #(
  parameter int unsigned DW = 36,
  parameter int unsigned VW = 24
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  logic [DW-1:0] dividend_i,
  input  logic [VW-1:0] divisor_i,
  output logic          done_o,
  output logic [DW-1:0] quotient_o
);

  localparam int unsigned CW = $clog2(DW);

  logic          busy_q, busy_d;
  logic          done_q, done_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic [DW-1:0] dvd_q, dvd_d;
  logic [VW-1:0] rem_q, rem_d;
  logic [VW-1:0] dvs_q, dvs_d;

  logic [VW:0]   rem_sh;
  logic [VW:0]   diff;
  logic          ge;

  assign rem_sh = {rem_q, dvd_q[DW-1]};
  assign ge     = rem_sh >= {1'b0, dvs_q};
  assign diff   = rem_sh - {1'b0, dvs_q};

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    dvd_d  = dvd_q;
    rem_d  = rem_q;
    dvs_d  = dvs_q;
    if (start_i && !busy_q) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      dvd_d  = dividend_i;
      rem_d  = '0;
      dvs_d  = divisor_i;
    end else if (busy_q) begin
      // shift in one dividend bit, subtract when it fits
      rem_d = ge ? diff[VW-1:0] : rem_sh[VW-1:0];
      dvd_d = {dvd_q[DW-2:0], ge};
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == CW'(DW - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dvd_q <= dvd_d;
    rem_q <= rem_d;
    dvs_q <= dvs_d;
  end

  assign done_o     = done_q;
  assign quotient_o = dvd_q;

endmodule

[sv/frequency_band_meter_adc_stats.sv]
// Top level: edge counter, millisecond windows, sample statistics and band classifier.
//
//  channel   dir  handshake                      payload (lowest bit first)
//  s_axis    in   s_axis_tvalid_i/s_axis_tready_o tdata: edge_req, ms_tick, adc_sample;
//                                                 tuser: adc_valid
//  m_axis    out  m_axis_tvalid_o/m_axis_tready_i tdata: freq_hz, band, sample_min,
//                                                 sample_max, sample_mean
//  cfg       in   cfg_we_i (no wait)              cfg_addr_i index, cfg_data_i value
//
// An item closing a measure window runs the multiply steps and a frequency
// division, one closing a display window a mean division, classify and emit;
// if both close, the frequency division comes first. Division is bit-serial
// (DIV_W = 36 at the default widths). A display result waits in the output
// register while later items are taken; the sequencer holds only if a second
// result is due before the first is taken. Reset restores register defaults
// and clears all counters and statistics.
module frequency_band_meter_adc_stats #(
  parameter int unsigned SAMPLE_BITS = 12,
  parameter int unsigned COUNT_BITS  = 24
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  // edge_req [0], ms_tick [1], adc_sample [SAMPLE_BITS+1:2]
  input  logic [((SAMPLE_BITS+2+7)/8)*8-1:0]    s_axis_tdata_i,
  // adc_valid [0]
  input  logic                                 s_axis_tuser_i,
  input  logic                                 s_axis_tvalid_i,
  output logic                                 s_axis_tready_o,
  // freq_hz [19:0], band [22:20], sample_min, sample_max, sample_mean above
  output logic [((23+3*SAMPLE_BITS+7)/8)*8-1:0] m_axis_tdata_o,
  output logic                                 m_axis_tvalid_o,
  input  logic                                 m_axis_tready_i,
  input  logic                                 cfg_we_i,
  input  logic [fbm_pkg::CFG_ADDR_W-1:0]        cfg_addr_i,
  input  logic [fbm_pkg::CFG_W-1:0]             cfg_data_i
);

  localparam int unsigned PROD_W = COUNT_BITS + 10;
  localparam int unsigned SUM_W  = SAMPLE_BITS + COUNT_BITS;
  localparam int unsigned DIV_W  = (PROD_W > SUM_W) ? PROD_W : SUM_W;
  localparam int unsigned OUT_W  = ((23 + 3 * SAMPLE_BITS + 7) / 8) * 8;
  localparam int unsigned PW     = fbm_pkg::PERIOD_W;
  localparam int unsigned FW     = fbm_pkg::FREQ_W;

  // configuration registers
  logic [PW-1:0] meas_period_q, disp_period_q;
  logic [FW-1:0] neutral_q, valid_a_q, valid_b_q, tol_q, silence_q;

  // running state
  fbm_pkg::state_e state_q, state_d;
  logic [COUNT_BITS-1:0]  edge_cnt_q, edge_cnt_d;
  logic [PW-1:0]          meas_cnt_q, meas_cnt_d;
  logic [PW-1:0]          disp_cnt_q, disp_cnt_d;
  logic [FW-1:0]          last_freq_q, last_freq_d;
  logic [SAMPLE_BITS-1:0] win_min_q, win_min_d;
  logic [SAMPLE_BITS-1:0] win_max_q, win_max_d;
  logic [SUM_W-1:0]       win_sum_q, win_sum_d;
  logic [COUNT_BITS-1:0]  win_cnt_q, win_cnt_d;
  logic                   meas_due_q, meas_due_d;
  logic                   disp_due_q, disp_due_d;
  logic [PROD_W-1:0]      prod_q, prod_d;
  logic [2:0]             band_q, band_d;
  logic [SAMPLE_BITS-1:0] mean_q, mean_d;

  // output register
  logic                   m_valid_q, m_valid_d;
  logic [FW-1:0]          m_freq_q;
  logic [2:0]             m_band_q;
  logic [SAMPLE_BITS-1:0] m_min_q, m_max_q, m_mean_q;

  logic                   accept;
  logic                   edge_req, ms_tick, adc_valid;
  logic [SAMPLE_BITS-1:0] adc_sample;
  logic [PW-1:0]          meas_p, disp_p;
  logic [PW-1:0]          meas_next, disp_next;
  logic                   emit_ok;
  logic                   emit;

  logic                   div_start;
  logic [DIV_W-1:0]       div_dividend;
  logic [COUNT_BITS-1:0]  div_divisor;
  logic                   div_done;
  logic [DIV_W-1:0]       div_quo;

  logic [2:0]             band_code;

  assign edge_req   = s_axis_tdata_i[0];
  assign ms_tick    = s_axis_tdata_i[1];
  assign adc_sample = s_axis_tdata_i[SAMPLE_BITS+1:2];
  assign adc_valid  = s_axis_tuser_i;

  assign s_axis_tready_o = (state_q == fbm_pkg::ST_IDLE);
  assign accept          = s_axis_tvalid_i && s_axis_tready_o;

  // a period of zero acts as one
  assign meas_p    = (meas_period_q == '0) ? PW'(1) : meas_period_q;
  assign disp_p    = (disp_period_q == '0) ? PW'(1) : disp_period_q;
  assign meas_next = meas_cnt_q + 1'b1;
  assign disp_next = disp_cnt_q + 1'b1;

  assign emit_ok = !m_valid_q || m_axis_tready_i;
  assign emit    = (state_q == fbm_pkg::ST_EMIT) && emit_ok;

  // ---------------------------------------------------------------------------
  // configuration writes
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      meas_period_q <= fbm_pkg::RST_MEASURE_PERIOD;
      disp_period_q <= fbm_pkg::RST_DISPLAY_PERIOD;
      neutral_q     <= fbm_pkg::RST_NEUTRAL_FREQ;
      valid_a_q     <= fbm_pkg::RST_VALID_A_FREQ;
      valid_b_q     <= fbm_pkg::RST_VALID_B_FREQ;
      tol_q         <= fbm_pkg::RST_BAND_TOL;
      silence_q     <= fbm_pkg::RST_SILENCE_THR;
    end else if (cfg_we_i) begin
      case (cfg_addr_i)
        fbm_pkg::REG_MEASURE_PERIOD: meas_period_q <= cfg_data_i[PW-1:0];
        fbm_pkg::REG_DISPLAY_PERIOD: disp_period_q <= cfg_data_i[PW-1:0];
        fbm_pkg::REG_NEUTRAL_FREQ:   neutral_q     <= cfg_data_i[FW-1:0];
        fbm_pkg::REG_VALID_A_FREQ:   valid_a_q     <= cfg_data_i[FW-1:0];
        fbm_pkg::REG_VALID_B_FREQ:   valid_b_q     <= cfg_data_i[FW-1:0];
        fbm_pkg::REG_BAND_TOL:       tol_q         <= cfg_data_i[FW-1:0];
        fbm_pkg::REG_SILENCE_THR:    silence_q     <= cfg_data_i[FW-1:0];
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // band classifier: bands are inclusive and clip at zero on the low side
  // ---------------------------------------------------------------------------
  function automatic logic in_band(input logic [FW-1:0] f, input logic [FW-1:0] centre,
                                   input logic [FW-1:0] tol);
    logic [FW-1:0] lo;
    logic [FW:0]   hi;
    lo = (centre > tol) ? (centre - tol) : '0;
    hi = {1'b0, centre} + {1'b0, tol};
    return (f >= lo) && ({1'b0, f} <= hi);
  endfunction

  always_comb begin
    if (last_freq_q < silence_q) begin
      band_code = fbm_pkg::BAND_NONE;
    end else if (in_band(last_freq_q, neutral_q, tol_q)) begin
      band_code = fbm_pkg::BAND_NEUTRAL;
    end else if (in_band(last_freq_q, valid_a_q, tol_q)) begin
      band_code = fbm_pkg::BAND_VALID_A;
    end else if (in_band(last_freq_q, valid_b_q, tol_q)) begin
      band_code = fbm_pkg::BAND_VALID_B;
    end else begin
      band_code = fbm_pkg::BAND_UNKNOWN;
    end
  end

  // ---------------------------------------------------------------------------
  // sequencer: next state
  // ---------------------------------------------------------------------------
  always_comb begin
    state_d = state_q;
    case (state_q)
      fbm_pkg::ST_IDLE: begin
        if (accept) begin
          if (meas_due_d) begin
            state_d = fbm_pkg::ST_MUL_A;
          end else if (disp_due_d) begin
            state_d = fbm_pkg::ST_MEAN_GO;
          end
        end
      end
      fbm_pkg::ST_MUL_A:   state_d = fbm_pkg::ST_MUL_B;
      fbm_pkg::ST_MUL_B:   state_d = fbm_pkg::ST_FREQ_GO;
      fbm_pkg::ST_FREQ_GO: state_d = fbm_pkg::ST_FREQ_WAIT;
      fbm_pkg::ST_FREQ_WAIT: begin
        if (div_done) begin
          state_d = disp_due_q ? fbm_pkg::ST_MEAN_GO : fbm_pkg::ST_IDLE;
        end
      end
      fbm_pkg::ST_MEAN_GO: state_d = fbm_pkg::ST_MEAN_WAIT;
      fbm_pkg::ST_MEAN_WAIT: begin
        if (div_done) begin
          state_d = fbm_pkg::ST_CLASSIFY;
        end
      end
      fbm_pkg::ST_CLASSIFY: state_d = fbm_pkg::ST_EMIT;
      fbm_pkg::ST_EMIT: begin
        if (emit_ok) begin
          state_d = fbm_pkg::ST_IDLE;
        end
      end
      default: state_d = fbm_pkg::ST_IDLE;
    endcase
  end

  // ---------------------------------------------------------------------------
  // sequencer: datapath and divider control
  // ---------------------------------------------------------------------------
  always_comb begin
    edge_cnt_d   = edge_cnt_q;
    meas_cnt_d   = meas_cnt_q;
    disp_cnt_d   = disp_cnt_q;
    last_freq_d  = last_freq_q;
    win_min_d    = win_min_q;
    win_max_d    = win_max_q;
    win_sum_d    = win_sum_q;
    win_cnt_d    = win_cnt_q;
    meas_due_d   = meas_due_q;
    disp_due_d   = disp_due_q;
    prod_d       = prod_q;
    band_d       = band_q;
    mean_d       = mean_q;
    div_start    = 1'b0;
    div_dividend = DIV_W'(prod_q);
    div_divisor  = COUNT_BITS'(meas_p);

    case (state_q)
      fbm_pkg::ST_IDLE: begin
        meas_due_d = 1'b0;
        disp_due_d = 1'b0;
        if (accept) begin
          // count the edge, saturating
          if (edge_req && (edge_cnt_q != '1)) begin
            edge_cnt_d = edge_cnt_q + 1'b1;
          end
          // take the sample; the sum freezes once the count is full
          if (adc_valid) begin
            if (adc_sample < win_min_q) win_min_d = adc_sample;
            if (adc_sample > win_max_q) win_max_d = adc_sample;
            if (win_cnt_q != '1) begin
              win_sum_d = win_sum_q + SUM_W'(adc_sample);
              win_cnt_d = win_cnt_q + 1'b1;
            end
          end
          // advance the millisecond windows
          if (ms_tick) begin
            meas_due_d = (meas_next >= meas_p);
            disp_due_d = (disp_next >= disp_p);
            meas_cnt_d = meas_due_d ? '0 : meas_next;
            disp_cnt_d = disp_due_d ? '0 : disp_next;
          end
        end
      end
      fbm_pkg::ST_MUL_A: begin
        // count * 1000 = count * 1024 - count * 16 - count * 8
        prod_d = (PROD_W'(edge_cnt_q) << 10) - (PROD_W'(edge_cnt_q) << 4);
      end
      fbm_pkg::ST_MUL_B: begin
        prod_d     = prod_q - (PROD_W'(edge_cnt_q) << 3);
        edge_cnt_d = '0;
      end
      fbm_pkg::ST_FREQ_GO: begin
        div_start = 1'b1;
      end
      fbm_pkg::ST_FREQ_WAIT: begin
        if (div_done) begin
          last_freq_d = (|div_quo[DIV_W-1:FW]) ? '1 : div_quo[FW-1:0];
        end
      end
      fbm_pkg::ST_MEAN_GO: begin
        div_start    = 1'b1;
        div_dividend = DIV_W'(win_sum_q);
        div_divisor  = win_cnt_q;
      end
      fbm_pkg::ST_MEAN_WAIT: ;
      fbm_pkg::ST_CLASSIFY: begin
        band_d = band_code;
        mean_d = (win_cnt_q == '0) ? '0 : div_quo[SAMPLE_BITS-1:0];
      end
      fbm_pkg::ST_EMIT: begin
        if (emit_ok) begin
          win_min_d = '1;
          win_max_d = '0;
          win_sum_d = '0;
          win_cnt_d = '0;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= fbm_pkg::ST_IDLE;
      edge_cnt_q  <= '0;
      meas_cnt_q  <= '0;
      disp_cnt_q  <= '0;
      last_freq_q <= '0;
      win_min_q   <= '1;
      win_max_q   <= '0;
      win_sum_q   <= '0;
      win_cnt_q   <= '0;
      meas_due_q  <= 1'b0;
      disp_due_q  <= 1'b0;
    end else begin
      state_q     <= state_d;
      edge_cnt_q  <= edge_cnt_d;
      meas_cnt_q  <= meas_cnt_d;
      disp_cnt_q  <= disp_cnt_d;
      last_freq_q <= last_freq_d;
      win_min_q   <= win_min_d;
      win_max_q   <= win_max_d;
      win_sum_q   <= win_sum_d;
      win_cnt_q   <= win_cnt_d;
      meas_due_q  <= meas_due_d;
      disp_due_q  <= disp_due_d;
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q <= prod_d;
    band_q <= band_d;
    mean_q <= mean_d;
  end

  // ---------------------------------------------------------------------------
  // shared divider: frequency first, then the window mean
  // ---------------------------------------------------------------------------
  fbm_div #(
    .DW (DIV_W),
    .VW (COUNT_BITS)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dividend),
    .divisor_i  (div_divisor),
    .done_o     (div_done),
    .quotient_o (div_quo)
  );

  // ---------------------------------------------------------------------------
  // output register: hold a result until its transfer completes
  // ---------------------------------------------------------------------------
  always_comb begin
    m_valid_d = m_valid_q;
    if (m_valid_q && m_axis_tready_i) begin
      m_valid_d = 1'b0;
    end
    if (emit) begin
      m_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else begin
      m_valid_q <= m_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      m_freq_q <= last_freq_q;
      m_band_q <= band_q;
      m_min_q  <= win_min_q;
      m_max_q  <= win_max_q;
      m_mean_q <= mean_q;
    end
  end

  assign m_axis_tvalid_o = m_valid_q;
  assign m_axis_tdata_o  = OUT_W'({m_mean_q, m_max_q, m_min_q, m_band_q, m_freq_q});

  // ---------------------------------------------------------------------------
  // assertions
  // ---------------------------------------------------------------------------
  a_done_when_waiting: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done |-> (state_q == fbm_pkg::ST_FREQ_WAIT || state_q == fbm_pkg::ST_MEAN_WAIT))
    else $error("divider finished outside a wait state");

  a_emit_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == fbm_pkg::ST_EMIT && m_valid_q && !m_axis_tready_i)
      |=> (state_q == fbm_pkg::ST_EMIT && m_valid_q))
    else $error("pending result overwritten");

  a_quiet_item_one_cycle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && !meas_due_d && !disp_due_d) |=> s_axis_tready_o)
    else $error("item without window close stalled the input");

  a_min_le_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (win_cnt_q != '0) |-> (win_min_q <= win_max_q))
    else $error("window minimum above maximum");

endmodule
